// ===== hdl/fsbs_pkg.sv =====
// Shared types and constants of the flow sensor bring-up and sample block.
// No dependencies; every other file of the block refers to it by scoped names.
package fsbs_pkg;

   localparam int NOW_W      = 32;
   localparam int WORD_W     = 16;
   localparam int CHK_W      = 8;
   localparam int PHASE_W    = 4;
   localparam int CMD_W      = 3;
   localparam int FLOW_W     = 25;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CHK_W-1:0]   CRC_INIT   = 8'hFF;
   localparam logic [CHK_W-1:0]   CRC_POLY   = 8'h31;
   localparam logic [COUNT_W-1:0] COUNT_SAT  = 8'hFF;
   localparam logic [FLOW_W-1:0]  FLOW_MAX   = 25'h0FF_FFFF;

   localparam logic [WORD_W-1:0]  RESET_WAIT_DEFAULT  = 16'd100;
   localparam logic [WORD_W-1:0]  START_WAIT_DEFAULT  = 16'd100;
   localparam logic [WORD_W-1:0]  PACKET_WAIT_DEFAULT = 16'd10;
   localparam logic [WORD_W-1:0]  READ_PERIOD_DEFAULT = 16'd10;
   localparam logic [COUNT_W-1:0] MAX_ERRORS_DEFAULT  = 8'd5;

   typedef enum logic [PHASE_W-1:0] {
      PH_RESET     = 4'd0,
      PH_RESETTING = 4'd1,
      PH_STOP      = 4'd2,
      PH_STOPPING  = 4'd3,
      PH_SETTINGS  = 4'd4,
      PH_START     = 4'd5,
      PH_STARTING  = 4'd6,
      PH_DISCARD   = 4'd7,
      PH_NEWPACKET = 4'd8,
      PH_RUNNING   = 4'd9
   } phase_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE          = 3'd0,
      CMD_SOFT_RESET    = 3'd1,
      CMD_STOP          = 3'd2,
      CMD_READ_SETTINGS = 3'd3,
      CMD_START_AIR     = 3'd4,
      CMD_DISCARD_READ  = 3'd5,
      CMD_SAMPLE_READ   = 3'd6
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESET_WAIT  = 3'd0,
      CSR_START_WAIT  = 3'd1,
      CSR_PACKET_WAIT = 3'd2,
      CSR_READ_PERIOD = 3'd3,
      CSR_MAX_ERRORS  = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_DIVIDE,
      CTRL_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } ctrl_cmd_type;

endpackage

// ===== hdl/fsbs_req_if.sv =====
// Poll channel of the flow sensor block: valid, ready and one poll's payload.
// Depends on fsbs_pkg for field widths.
interface fsbs_req_if;
   logic                          valid;
   logic                          ready;
   logic [fsbs_pkg::NOW_W-1:0]    now_ms;
   logic                          bus_ok;
   logic [fsbs_pkg::WORD_W-1:0]   rx_first_word;
   logic [fsbs_pkg::WORD_W-1:0]   rx_second_word;
   logic [fsbs_pkg::WORD_W-1:0]   rx_third_word;
   logic [fsbs_pkg::CHK_W-1:0]    rx_check_byte;

   modport source (output valid, now_ms, bus_ok, rx_first_word, rx_second_word,
                   rx_third_word, rx_check_byte, input ready);
   modport sink (input valid, now_ms, bus_ok, rx_first_word, rx_second_word,
                 rx_third_word, rx_check_byte, output ready);
endinterface

// ===== hdl/fsbs_rsp_if.sv =====
// Result channel of the flow sensor block: valid, ready and one result's payload.
// Depends on fsbs_pkg for field widths.
interface fsbs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [fsbs_pkg::PHASE_W-1:0]        phase;
   logic [fsbs_pkg::CMD_W-1:0]          command;
   logic signed [fsbs_pkg::FLOW_W-1:0]  flow_q8;
   logic                                flow_valid;
   logic [fsbs_pkg::COUNT_W-1:0]        error_count;
   logic [fsbs_pkg::WORD_W-1:0]         flow_unit;

   modport source (output valid, phase, command, flow_q8, flow_valid, error_count,
                   flow_unit, input ready);
   modport sink (input valid, phase, command, flow_q8, flow_valid, error_count,
                 flow_unit, output ready);
endinterface

// ===== hdl/fsbs_csr_if.sv =====
// Configuration write channel of the flow sensor block: valid, ready, index, data.
// Depends on fsbs_pkg for field widths.
interface fsbs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fsbs_pkg::CSR_IDX_W-1:0]    index;
   logic [fsbs_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/fsbs_ctrl.sv =====
// Controller of the flow sensor block: handshakes and the divide step counter.
// Depends on fsbs_pkg; drives fsbs_dpath through a ctrl_cmd_type struct.
module fsbs_ctrl #(
   parameter int STEPS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fsbs_pkg::ctrl_cmd_type cmd
);

   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   fsbs_pkg::ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0]         step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsbs_pkg::CTRL_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         fsbs_pkg::CTRL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = fsbs_pkg::CTRL_DIVIDE;
            end
         end
         fsbs_pkg::CTRL_DIVIDE: begin
            cmd.step = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = fsbs_pkg::CTRL_COMMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         fsbs_pkg::CTRL_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = fsbs_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = fsbs_pkg::CTRL_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/fsbs_dpath.sv =====
// Datapath of the flow sensor block: settings, sequence state, bit-serial CRC-8,
// restoring divider and the result register. Depends on fsbs_pkg; driven by fsbs_ctrl.
module fsbs_dpath #(
   parameter int TIME_BITS     = 32,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fsbs_pkg::ctrl_cmd_type              cmd,
   input  logic                                csr_we,
   input  logic [fsbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fsbs_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [fsbs_pkg::NOW_W-1:0]          now_ms,
   input  logic                                bus_ok,
   input  logic [fsbs_pkg::WORD_W-1:0]         rx_first_word,
   input  logic [fsbs_pkg::WORD_W-1:0]         rx_second_word,
   input  logic [fsbs_pkg::WORD_W-1:0]         rx_third_word,
   input  logic [fsbs_pkg::CHK_W-1:0]          rx_check_byte,
   output logic [fsbs_pkg::PHASE_W-1:0]        phase,
   output logic [fsbs_pkg::CMD_W-1:0]          command,
   output logic signed [fsbs_pkg::FLOW_W-1:0]  flow_q8,
   output logic                                flow_valid,
   output logic [fsbs_pkg::COUNT_W-1:0]        error_count,
   output logic [fsbs_pkg::WORD_W-1:0]         flow_unit
);

   localparam int WW = fsbs_pkg::WORD_W;
   localparam int NW = WW + FRACTION_BITS;
   localparam int QW = (NW > fsbs_pkg::FLOW_W) ? NW : fsbs_pkg::FLOW_W;

   // Settings written through the configuration port.
   logic [WW-1:0]                 reset_wait_ff, start_wait_ff, packet_wait_ff;
   logic [WW-1:0]                 read_period_ff;
   logic [fsbs_pkg::COUNT_W-1:0]  max_errors_ff;

   // Sequence state.
   fsbs_pkg::phase_type           phase_ff, phase_in;
   logic [TIME_BITS-1:0]          timer_ff, timer_in;
   logic [TIME_BITS-1:0]          last_ff, last_in;
   logic [fsbs_pkg::COUNT_W-1:0]  fail_ff, fail_in;
   logic [WW-1:0]                 scale_ff, offset_ff, unit_ff;
   logic                          store_settings;

   // Latched poll and work registers.
   logic [TIME_BITS-1:0]          now_ff;
   logic                          ok_ff;
   logic [WW-1:0]                 w1_ff, w2_ff, w3_ff;
   logic [fsbs_pkg::CHK_W-1:0]    chk_ff;
   logic                          neg_ff;
   logic [fsbs_pkg::CHK_W-1:0]    crc_ff, crc_in;
   logic [WW-1:0]                 crc_data_ff, crc_left_ff;
   logic [NW-1:0]                 num_ff, num_in;
   logic [WW-1:0]                 rem_ff, rem_in;

   // Result register.
   logic [fsbs_pkg::PHASE_W-1:0]        phase_out_ff;
   logic [fsbs_pkg::CMD_W-1:0]          cmd_out_ff;
   logic signed [fsbs_pkg::FLOW_W-1:0]  flow_out_ff;
   logic                                valid_out_ff;
   logic [fsbs_pkg::COUNT_W-1:0]        fail_out_ff;
   logic [WW-1:0]                       unit_out_ff;

   logic [WW-1:0]                 mag;
   logic                          crc_fb;
   logic [WW:0]                   trial;
   logic                          trial_ge;
   logic [TIME_BITS-1:0]          rd_diff, ph_diff;
   logic                          rd_due, waited;
   logic [WW-1:0]                 wait_sel;
   logic [fsbs_pkg::COUNT_W-1:0]  fail_inc;
   logic                          check_good;
   logic [QW-1:0]                 q_ext;
   logic [fsbs_pkg::FLOW_W-1:0]   q_sat;
   logic signed [fsbs_pkg::FLOW_W-1:0] flow_c;
   fsbs_pkg::cmd_type             cmd_c;
   logic                          valid_c;
   logic [WW-1:0]                 unit_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_wait_ff  <= fsbs_pkg::RESET_WAIT_DEFAULT;
         start_wait_ff  <= fsbs_pkg::START_WAIT_DEFAULT;
         packet_wait_ff <= fsbs_pkg::PACKET_WAIT_DEFAULT;
         read_period_ff <= fsbs_pkg::READ_PERIOD_DEFAULT;
         max_errors_ff  <= fsbs_pkg::MAX_ERRORS_DEFAULT;
      end else if (csr_we) begin
         case (csr_index)
            fsbs_pkg::CSR_RESET_WAIT:  reset_wait_ff  <= csr_data;
            fsbs_pkg::CSR_START_WAIT:  start_wait_ff  <= csr_data;
            fsbs_pkg::CSR_PACKET_WAIT: packet_wait_ff <= csr_data;
            fsbs_pkg::CSR_READ_PERIOD: read_period_ff <= csr_data;
            fsbs_pkg::CSR_MAX_ERRORS:  max_errors_ff  <= csr_data[fsbs_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= fsbs_pkg::PH_RESET;
         timer_ff  <= '0;
         last_ff   <= '0;
         fail_ff   <= '0;
         scale_ff  <= '0;
         offset_ff <= '0;
         unit_ff   <= '0;
      end else if (cmd.commit) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         last_ff  <= last_in;
         fail_ff  <= fail_in;
         if (store_settings) begin
            scale_ff  <= w1_ff;
            offset_ff <= w2_ff;
            unit_ff   <= w3_ff;
         end
      end
   end

   // Load magnitude for seeding the divider, and one step of the CRC and the divider.
   always_comb begin
      mag    = (rx_first_word >= offset_ff) ? rx_first_word - offset_ff
                                            : offset_ff - rx_first_word;
      crc_fb = crc_ff[7] ^ crc_data_ff[WW-1];
      crc_in = {crc_ff[6:0], 1'b0} ^ (crc_fb ? fsbs_pkg::CRC_POLY : '0);
      trial    = {rem_ff, num_ff[NW-1]};
      trial_ge = trial >= {1'b0, scale_ff};
      rem_in   = trial_ge ? WW'(trial - {1'b0, scale_ff}) : trial[WW-1:0];
      num_in   = {num_ff[NW-2:0], trial_ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff      <= TIME_BITS'(now_ms);
         ok_ff       <= bus_ok;
         w1_ff       <= rx_first_word;
         w2_ff       <= rx_second_word;
         w3_ff       <= rx_third_word;
         chk_ff      <= rx_check_byte;
         neg_ff      <= rx_first_word < offset_ff;
         crc_ff      <= fsbs_pkg::CRC_INIT;
         crc_data_ff <= rx_first_word;
         crc_left_ff <= '1;
         num_ff      <= NW'(mag) << FRACTION_BITS;
         rem_ff      <= '0;
      end else if (cmd.step) begin
         if (crc_left_ff[WW-1]) begin
            crc_ff      <= crc_in;
            crc_data_ff <= {crc_data_ff[WW-2:0], 1'b0};
            crc_left_ff <= {crc_left_ff[WW-2:0], 1'b0};
         end
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   // Commit: one poll's step of the sequence.
   always_comb begin
      rd_diff    = now_ff - last_ff;
      rd_due     = rd_diff >= TIME_BITS'(read_period_ff);
      ph_diff    = now_ff - timer_ff;
      case (phase_ff)
         fsbs_pkg::PH_RESETTING: wait_sel = reset_wait_ff;
         fsbs_pkg::PH_NEWPACKET: wait_sel = packet_wait_ff;
         default:                wait_sel = start_wait_ff;
      endcase
      waited     = ph_diff >= TIME_BITS'(wait_sel);
      fail_inc   = (fail_ff == fsbs_pkg::COUNT_SAT) ? fail_ff : fail_ff + 1'b1;
      check_good = (chk_ff != '0) && (crc_ff == chk_ff) && (scale_ff != '0);
      q_ext      = QW'(num_ff);
      q_sat      = (q_ext > QW'(fsbs_pkg::FLOW_MAX)) ? fsbs_pkg::FLOW_MAX
                                                     : q_ext[fsbs_pkg::FLOW_W-1:0];

      phase_in       = phase_ff;
      timer_in       = timer_ff;
      last_in        = rd_due ? now_ff : last_ff;
      fail_in        = fail_ff;
      store_settings = 1'b0;
      cmd_c          = fsbs_pkg::CMD_NONE;
      valid_c        = 1'b0;
      case (phase_ff)
         fsbs_pkg::PH_RESET, fsbs_pkg::PH_STOP, fsbs_pkg::PH_START: begin
            case (phase_ff)
               fsbs_pkg::PH_RESET: begin
                  cmd_c    = fsbs_pkg::CMD_SOFT_RESET;
                  phase_in = ok_ff ? fsbs_pkg::PH_RESETTING : phase_ff;
               end
               fsbs_pkg::PH_STOP: begin
                  cmd_c    = fsbs_pkg::CMD_STOP;
                  phase_in = ok_ff ? fsbs_pkg::PH_STOPPING : phase_ff;
               end
               default: begin
                  cmd_c    = fsbs_pkg::CMD_START_AIR;
                  phase_in = ok_ff ? fsbs_pkg::PH_STARTING : phase_ff;
               end
            endcase
            if (ok_ff) begin
               fail_in  = '0;
               timer_in = now_ff;
            end else begin
               fail_in = fail_inc;
            end
         end
         fsbs_pkg::PH_RESETTING: begin
            if (waited) begin
               phase_in = fsbs_pkg::PH_STOP;
            end
         end
         fsbs_pkg::PH_STOPPING: begin
            if (waited) begin
               phase_in = fsbs_pkg::PH_SETTINGS;
            end
         end
         fsbs_pkg::PH_STARTING: begin
            if (waited) begin
               phase_in = fsbs_pkg::PH_DISCARD;
            end
         end
         fsbs_pkg::PH_SETTINGS: begin
            cmd_c = fsbs_pkg::CMD_READ_SETTINGS;
            if (ok_ff) begin
               store_settings = 1'b1;
               fail_in        = '0;
               timer_in       = now_ff;
               phase_in       = fsbs_pkg::PH_START;
            end else begin
               fail_in = fail_inc;
            end
         end
         fsbs_pkg::PH_DISCARD: begin
            cmd_c    = fsbs_pkg::CMD_DISCARD_READ;
            fail_in  = ok_ff ? '0 : fail_inc;
            timer_in = now_ff;
            phase_in = fsbs_pkg::PH_NEWPACKET;
         end
         fsbs_pkg::PH_NEWPACKET: begin
            if (waited) begin
               fail_in  = '0;
               timer_in = now_ff;
               phase_in = fsbs_pkg::PH_RUNNING;
            end
         end
         fsbs_pkg::PH_RUNNING: begin
            if (rd_due) begin
               cmd_c = fsbs_pkg::CMD_SAMPLE_READ;
               if (!ok_ff) begin
                  fail_in = fail_inc;
               end else begin
                  valid_c = check_good;
               end
            end
         end
         default: begin
            phase_in = fsbs_pkg::PH_RESET;
         end
      endcase
      if (fail_in >= max_errors_ff) begin
         phase_in = fsbs_pkg::PH_RESET;
      end

      if (!valid_c) begin
         flow_c = '0;
      end else if (neg_ff) begin
         flow_c = -$signed(q_sat);
      end else begin
         flow_c = $signed(q_sat);
      end
      unit_c = store_settings ? w3_ff : unit_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         phase_out_ff <= phase_in;
         cmd_out_ff   <= cmd_c;
         flow_out_ff  <= flow_c;
         valid_out_ff <= valid_c;
         fail_out_ff  <= fail_in;
         unit_out_ff  <= unit_c;
      end
   end

   assign phase       = phase_out_ff;
   assign command     = cmd_out_ff;
   assign flow_q8     = flow_out_ff;
   assign flow_valid  = valid_out_ff;
   assign error_count = fail_out_ff;
   assign flow_unit   = unit_out_ff;

endmodule

// ===== hdl/flow_sensor_bringup_and_sample.sv =====
// Top level of the flow sensor bring-up sequencer and sampler.
// Depends on fsbs_pkg, the three channel interfaces, fsbs_ctrl and fsbs_dpath.
//
// Each accepted poll beat gives exactly one result beat. After acceptance a poll
// passes through the restoring divider, which produces one quotient bit per
// cycle over 16 + FRACTION_BITS bits, and is then committed; the CRC-8 check
// runs bit-serially over the 16 data bits alongside the first divide steps.
// One poll is worked on at a time; the next poll is taken in the cycle after
// the current one has been committed to the result register, even while that
// result still waits to be taken. A commit waits while an earlier result is
// still held in the result register.
// Configuration writes are always accepted and must only be issued while the
// block is idle.
module flow_sensor_bringup_and_sample #(
   parameter int TIME_BITS     = 32,
   parameter int FRACTION_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   fsbs_req_if.sink   req_bus,
   fsbs_rsp_if.source rsp_bus,
   fsbs_csr_if.sink   csr_bus
);

   fsbs_pkg::ctrl_cmd_type cmd;

   assign csr_bus.ready = 1'b1;

   fsbs_ctrl #(
      .STEPS (fsbs_pkg::WORD_W + FRACTION_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   fsbs_dpath #(
      .TIME_BITS     (TIME_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_we         (csr_bus.valid && csr_bus.ready),
      .csr_index      (csr_bus.index),
      .csr_data       (csr_bus.data),
      .now_ms         (req_bus.now_ms),
      .bus_ok         (req_bus.bus_ok),
      .rx_first_word  (req_bus.rx_first_word),
      .rx_second_word (req_bus.rx_second_word),
      .rx_third_word  (req_bus.rx_third_word),
      .rx_check_byte  (req_bus.rx_check_byte),
      .phase          (rsp_bus.phase),
      .command        (rsp_bus.command),
      .flow_q8        (rsp_bus.flow_q8),
      .flow_valid     (rsp_bus.flow_valid),
      .error_count    (rsp_bus.error_count),
      .flow_unit      (rsp_bus.flow_unit)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("poll accepted while a previous poll is still being divided");

   a_flow_only_on_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.flow_valid) |->
         (rsp_bus.command == fsbs_pkg::CMD_SAMPLE_READ))
      else $error("valid flow reported outside a sample read");

   a_flow_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.flow_valid) |-> (rsp_bus.flow_q8 == '0))
      else $error("nonzero flow reported without a valid flag");

endmodule

// ===== dv/flow_sensor_bringup_and_sample_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for flow_sensor_bringup_and_sample: sends polls, predicts each
// result beat with a behavioral model of the bring-up sequencer and checks every field.
// Depends on fsbs_pkg, the poll, result and configuration interfaces and the block.
module flow_sensor_bringup_and_sample_test;

   localparam int     TIME_BITS      = 32;
   localparam int     FRACTION_BITS  = 8;
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     SETTLE_CYCLES  = 40;
   localparam longint FLOW_LIMIT     = (longint'(1) <<< (fsbs_pkg::FLOW_W - 1)) - 1;

   typedef struct {
      logic [fsbs_pkg::NOW_W-1:0]  now_ms;
      logic                        bus_ok;
      logic [fsbs_pkg::WORD_W-1:0] first_word;
      logic [fsbs_pkg::WORD_W-1:0] second_word;
      logic [fsbs_pkg::WORD_W-1:0] third_word;
      logic [fsbs_pkg::CHK_W-1:0]  check_byte;
   } poll_type;

   typedef struct {
      fsbs_pkg::phase_type                phase;
      fsbs_pkg::cmd_type                  command;
      logic signed [fsbs_pkg::FLOW_W-1:0] flow_q8;
      logic                               flow_valid;
      logic [fsbs_pkg::COUNT_W-1:0]       error_count;
      logic [fsbs_pkg::WORD_W-1:0]        flow_unit;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;

   fsbs_req_if req_bus ();
   fsbs_rsp_if rsp_bus ();
   fsbs_csr_if csr_bus ();

   flow_sensor_bringup_and_sample #(
      .TIME_BITS     (TIME_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   // Sequencer state as the block should hold it.
   fsbs_pkg::phase_type          seq_phase;
   logic [fsbs_pkg::NOW_W-1:0]   seq_phase_start;
   logic [fsbs_pkg::NOW_W-1:0]   seq_last_read;
   logic [fsbs_pkg::COUNT_W-1:0] seq_failures;
   logic [fsbs_pkg::WORD_W-1:0]  seq_scale;
   logic [fsbs_pkg::WORD_W-1:0]  seq_offset;
   logic [fsbs_pkg::WORD_W-1:0]  seq_unit;

   logic [fsbs_pkg::WORD_W-1:0]  reset_wait;
   logic [fsbs_pkg::WORD_W-1:0]  start_wait;
   logic [fsbs_pkg::WORD_W-1:0]  packet_wait;
   logic [fsbs_pkg::WORD_W-1:0]  read_period;
   logic [fsbs_pkg::COUNT_W-1:0] max_errors;

   outcome_type                expected_outcomes[$];
   logic [fsbs_pkg::NOW_W-1:0] wall_ms;
   int                         mismatches;
   int                         quiet_cycles;
   int                         send_idle_pct;
   int                         recv_stall_pct;

   function automatic logic [fsbs_pkg::CHK_W-1:0] crc8_of(
      input logic [fsbs_pkg::WORD_W-1:0] word);
      logic [fsbs_pkg::CHK_W-1:0] crc;
      crc = fsbs_pkg::CRC_INIT;
      for (int i = fsbs_pkg::WORD_W - 1; i >= 0; i--) begin
         if (crc[fsbs_pkg::CHK_W-1] ^ word[i]) begin
            crc = {crc[fsbs_pkg::CHK_W-2:0], 1'b0} ^ fsbs_pkg::CRC_POLY;
         end else begin
            crc = {crc[fsbs_pkg::CHK_W-2:0], 1'b0};
         end
      end
      return crc;
   endfunction

   function automatic void count_failure();
      if (seq_failures != fsbs_pkg::COUNT_SAT) begin
         seq_failures = seq_failures + 1'b1;
      end
   endfunction

   function automatic void take_command(input poll_type p);
      if (p.bus_ok) begin
         seq_failures    = '0;
         seq_phase_start = p.now_ms;
         seq_phase       = fsbs_pkg::phase_type'(seq_phase + 1);
      end else begin
         count_failure();
      end
   endfunction

   function automatic outcome_type predict_outcome(input poll_type p);
      outcome_type                o;
      logic [fsbs_pkg::NOW_W-1:0] since_read;
      logic [fsbs_pkg::NOW_W-1:0] since_phase;
      longint                     diff;
      longint                     mag;
      longint                     quot;
      o.command    = fsbs_pkg::CMD_NONE;
      o.flow_q8    = '0;
      o.flow_valid = 1'b0;
      since_read   = p.now_ms - seq_last_read;
      since_phase  = p.now_ms - seq_phase_start;
      if (since_read >= read_period) begin
         seq_last_read = p.now_ms;
         if (seq_phase == fsbs_pkg::PH_RUNNING) begin
            o.command = fsbs_pkg::CMD_SAMPLE_READ;
            if (!p.bus_ok) begin
               count_failure();
            end else if (p.check_byte != '0 && crc8_of(p.first_word) == p.check_byte
                         && seq_scale != '0) begin
               diff = longint'(p.first_word) - longint'(seq_offset);
               mag  = (diff < 0) ? -diff : diff;
               quot = (mag <<< FRACTION_BITS) / longint'(seq_scale);
               if (quot > FLOW_LIMIT) begin
                  quot = FLOW_LIMIT;
               end
               o.flow_q8    = fsbs_pkg::FLOW_W'((diff < 0) ? -quot : quot);
               o.flow_valid = 1'b1;
            end
         end
      end
      case (seq_phase)
         fsbs_pkg::PH_RESET: begin
            o.command = fsbs_pkg::CMD_SOFT_RESET;
            take_command(p);
         end
         fsbs_pkg::PH_STOP: begin
            o.command = fsbs_pkg::CMD_STOP;
            take_command(p);
         end
         fsbs_pkg::PH_START: begin
            o.command = fsbs_pkg::CMD_START_AIR;
            take_command(p);
         end
         fsbs_pkg::PH_RESETTING: begin
            if (since_phase >= reset_wait) seq_phase = fsbs_pkg::PH_STOP;
         end
         fsbs_pkg::PH_STOPPING, fsbs_pkg::PH_STARTING: begin
            if (since_phase >= start_wait) begin
               seq_phase = fsbs_pkg::phase_type'(seq_phase + 1);
            end
         end
         fsbs_pkg::PH_SETTINGS: begin
            o.command = fsbs_pkg::CMD_READ_SETTINGS;
            if (p.bus_ok) begin
               seq_scale       = p.first_word;
               seq_offset      = p.second_word;
               seq_unit        = p.third_word;
               seq_failures    = '0;
               seq_phase_start = p.now_ms;
               seq_phase       = fsbs_pkg::PH_START;
            end else begin
               count_failure();
            end
         end
         fsbs_pkg::PH_DISCARD: begin
            o.command = fsbs_pkg::CMD_DISCARD_READ;
            if (p.bus_ok) begin
               seq_failures = '0;
            end else begin
               count_failure();
            end
            seq_phase_start = p.now_ms;
            seq_phase       = fsbs_pkg::PH_NEWPACKET;
         end
         fsbs_pkg::PH_NEWPACKET: begin
            if (since_phase >= packet_wait) begin
               seq_failures    = '0;
               seq_phase_start = p.now_ms;
               seq_phase       = fsbs_pkg::PH_RUNNING;
            end
         end
         fsbs_pkg::PH_RUNNING: begin
         end
         default: seq_phase = fsbs_pkg::PH_RESET;
      endcase
      if (seq_failures >= max_errors) seq_phase = fsbs_pkg::PH_RESET;
      o.phase       = seq_phase;
      o.error_count = seq_failures;
      o.flow_unit   = seq_unit;
      return o;
   endfunction

   task automatic send_poll(input poll_type p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.now_ms         <= p.now_ms;
      req_bus.bus_ok         <= p.bus_ok;
      req_bus.rx_first_word  <= p.first_word;
      req_bus.rx_second_word <= p.second_word;
      req_bus.rx_third_word  <= p.third_word;
      req_bus.rx_check_byte  <= p.check_byte;
      do @(posedge clock); while (!req_bus.ready);
      expected_outcomes.push_back(predict_outcome(p));
   endtask

   task automatic poll_after(input int unsigned dt, input logic ok,
                             input logic [fsbs_pkg::WORD_W-1:0] w1,
                             input logic [fsbs_pkg::WORD_W-1:0] w2,
                             input logic [fsbs_pkg::WORD_W-1:0] w3,
                             input logic [fsbs_pkg::CHK_W-1:0] chk);
      poll_type p;
      wall_ms       = wall_ms + dt;
      p.now_ms      = wall_ms;
      p.bus_ok      = ok;
      p.first_word  = w1;
      p.second_word = w2;
      p.third_word  = w3;
      p.check_byte  = chk;
      send_poll(p);
   endtask

   task automatic sample_after(input int unsigned dt, input logic [fsbs_pkg::WORD_W-1:0] raw);
      poll_after(dt, 1'b1, raw, fsbs_pkg::WORD_W'($urandom()), fsbs_pkg::WORD_W'($urandom()),
                 crc8_of(raw));
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input fsbs_pkg::csr_idx_type idx,
                                 input logic [fsbs_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         fsbs_pkg::CSR_RESET_WAIT:  reset_wait  = value;
         fsbs_pkg::CSR_START_WAIT:  start_wait  = value;
         fsbs_pkg::CSR_PACKET_WAIT: packet_wait = value;
         fsbs_pkg::CSR_READ_PERIOD: read_period = value;
         fsbs_pkg::CSR_MAX_ERRORS:  max_errors  = value[fsbs_pkg::COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [fsbs_pkg::WORD_W-1:0] rw,
                                 input logic [fsbs_pkg::WORD_W-1:0] sw,
                                 input logic [fsbs_pkg::WORD_W-1:0] pw,
                                 input logic [fsbs_pkg::WORD_W-1:0] rp,
                                 input logic [fsbs_pkg::COUNT_W-1:0] me);
      drain_results();
      write_register(fsbs_pkg::CSR_RESET_WAIT, rw);
      write_register(fsbs_pkg::CSR_START_WAIT, sw);
      write_register(fsbs_pkg::CSR_PACKET_WAIT, pw);
      write_register(fsbs_pkg::CSR_READ_PERIOD, rp);
      write_register(fsbs_pkg::CSR_MAX_ERRORS,
                     {{(fsbs_pkg::CSR_DATA_W - fsbs_pkg::COUNT_W){1'b0}}, me});
      csr_bus.valid <= 1'b0;
   endtask

   function automatic poll_type next_random_poll(input int fail_pct);
      poll_type p;
      int       longest;
      longest = int'(reset_wait);
      if (int'(start_wait) > longest) longest = int'(start_wait);
      if (int'(packet_wait) > longest) longest = int'(packet_wait);
      if (int'(read_period) > longest) longest = int'(read_period);
      case ($urandom_range(0, 19))
         0:                wall_ms = $urandom();
         1, 2, 3:          wall_ms = wall_ms + $urandom_range(0, 70000);
         4, 5, 6, 7, 8, 9: wall_ms = wall_ms + $urandom_range(0, longest + 2);
         default:          wall_ms = wall_ms + $urandom_range(0, 3);
      endcase
      p.now_ms      = wall_ms;
      p.bus_ok      = ($urandom_range(0, 99) >= fail_pct);
      p.first_word  = fsbs_pkg::WORD_W'($urandom());
      p.second_word = fsbs_pkg::WORD_W'($urandom());
      p.third_word  = fsbs_pkg::WORD_W'($urandom());
      p.check_byte  = fsbs_pkg::CHK_W'($urandom());
      if (seq_phase == fsbs_pkg::PH_SETTINGS) begin
         case ($urandom_range(0, 9))
            0:       p.first_word = '0;
            1:       p.first_word = 16'd1;
            2:       p.first_word = fsbs_pkg::WORD_W'($urandom_range(1, 16));
            default: ;
         endcase
         case ($urandom_range(0, 9))
            0:       p.second_word = '0;
            1:       p.second_word = '1;
            default: ;
         endcase
      end else if (seq_phase == fsbs_pkg::PH_RUNNING) begin
         case ($urandom_range(0, 9))
            0:       p.check_byte = '0;
            1:       ;
            default: p.check_byte = crc8_of(p.first_word);
         endcase
      end
      return p;
   endfunction

   task automatic run_random(input int count, input int idle_pct, input int stall_pct,
                             input int fail_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         send_poll(next_random_poll(fail_pct));
         if ($urandom_range(0, 99) == 0) drain_results();
      end
      drain_results();
   endtask

   task automatic test_bringup_sequence();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      poll_after(0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      poll_after(3, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      poll_after(50, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(50, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(100, 1'b0, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA);
      poll_after(1, 1'b0, 16'h1234, 16'h5678, 16'h9ABC, 8'h00);
      poll_after(1, 1'b1, 16'd1, 16'h8000, 16'hFFFF, 8'h00);
      poll_after(1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(100, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(1, 1'b0, 16'hBEEF, 16'h0000, 16'h0000, 8'h00);
      poll_after(10, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      sample_after(10, 16'hFFFF);
      sample_after(10, 16'h0000);
      poll_after(3, 1'b1, 16'h4321, 16'h0000, 16'h0000, crc8_of(16'h4321));
      poll_after(10, 1'b1, 16'h1111, 16'h0000, 16'h0000, 8'h00);
      poll_after(10, 1'b1, 16'hBEEF, 16'h0000, 16'h0000, crc8_of(16'hBEEF) ^ 8'h01);
      poll_after(10, 1'b0, 16'h2222, 16'h0000, 16'h0000, crc8_of(16'h2222));
   endtask

   task automatic test_zero_scale_and_limits();
      write_settings(16'd0, 16'd0, 16'd0, 16'd1, 8'd1);
      sample_after(1, 16'h7FFF);
      poll_after(1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(0, 1'b1, 16'h0000, 16'h0000, 16'h5A5A, 8'h00);
      poll_after(0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      poll_after(0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      sample_after(1, 16'h1234);
      poll_after(1, 1'b0, 16'h1234, 16'h0000, 16'h0000, crc8_of(16'h1234));
      write_settings(16'd0, 16'd0, 16'd0, 16'd1, 8'd0);
      poll_after(1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
   endtask

   task automatic test_failure_saturation();
      write_settings(16'd100, 16'd100, 16'd10, 16'd10, 8'd255);
      for (int n = 0; n < 260; n++) begin
         poll_after($urandom_range(0, 3), 1'b0, fsbs_pkg::WORD_W'($urandom()),
                    fsbs_pkg::WORD_W'($urandom()), fsbs_pkg::WORD_W'($urandom()),
                    fsbs_pkg::CHK_W'($urandom()));
      end
      poll_after(1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      drain_results();
   endtask

   task automatic test_random_at_defaults();
      write_settings(fsbs_pkg::RESET_WAIT_DEFAULT, fsbs_pkg::START_WAIT_DEFAULT,
                     fsbs_pkg::PACKET_WAIT_DEFAULT, fsbs_pkg::READ_PERIOD_DEFAULT,
                     fsbs_pkg::MAX_ERRORS_DEFAULT);
      run_random(350, 0, 0, 10);
   endtask

   task automatic test_random_fast_timing();
      write_settings(16'd0, 16'd0, 16'd0, 16'd1, 8'd1);
      run_random(300, 48, 0, 5);
   endtask

   task automatic test_random_long_waits();
      write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
      run_random(250, 0, 48, 10);
   endtask

   task automatic test_random_short_settings();
      write_settings(fsbs_pkg::WORD_W'($urandom_range(0, 40)),
                     fsbs_pkg::WORD_W'($urandom_range(0, 40)),
                     fsbs_pkg::WORD_W'($urandom_range(0, 40)),
                     fsbs_pkg::WORD_W'($urandom_range(1, 20)),
                     fsbs_pkg::COUNT_W'($urandom_range(1, 8)));
      run_random(350, 16, 16, 10);
   endtask

   task automatic test_random_wide_settings();
      write_settings(fsbs_pkg::WORD_W'($urandom_range(0, 65535)),
                     fsbs_pkg::WORD_W'($urandom_range(0, 65535)),
                     fsbs_pkg::WORD_W'($urandom_range(0, 65535)),
                     fsbs_pkg::WORD_W'($urandom_range(1, 65535)),
                     fsbs_pkg::COUNT_W'($urandom_range(1, 255)));
      run_random(250, 16, 16, 8);
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result beat with no poll outstanding: phase %0d command %0d",
                        $realtime, rsp_bus.phase, rsp_bus.command);
            end
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_bus.phase !== want.phase || rsp_bus.command !== want.command
                || rsp_bus.flow_q8 !== want.flow_q8 || rsp_bus.flow_valid !== want.flow_valid
                || rsp_bus.error_count !== want.error_count
                || rsp_bus.flow_unit !== want.flow_unit) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: expected phase %0d cmd %0d flow %0d valid %0b errors %0d unit %h",
                           $realtime, want.phase, want.command, want.flow_q8, want.flow_valid,
                           want.error_count, want.flow_unit);
                  $display("%0t: actual   phase %0d cmd %0d flow %0d valid %0b errors %0d unit %h",
                           $realtime, rsp_bus.phase, rsp_bus.command, rsp_bus.flow_q8,
                           rsp_bus.flow_valid, rsp_bus.error_count, rsp_bus.flow_unit);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("flow_sensor_bringup_and_sample test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.now_ms         = '0;
      req_bus.bus_ok         = 1'b0;
      req_bus.rx_first_word  = '0;
      req_bus.rx_second_word = '0;
      req_bus.rx_third_word  = '0;
      req_bus.rx_check_byte  = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = fsbs_pkg::CSR_RESET_WAIT;
      csr_bus.data           = '0;
      send_idle_pct          = 0;
      recv_stall_pct         = 0;
      mismatches             = 0;
      quiet_cycles           = 0;
      wall_ms                = '0;
      reset_wait             = fsbs_pkg::RESET_WAIT_DEFAULT;
      start_wait             = fsbs_pkg::START_WAIT_DEFAULT;
      packet_wait            = fsbs_pkg::PACKET_WAIT_DEFAULT;
      read_period            = fsbs_pkg::READ_PERIOD_DEFAULT;
      max_errors             = fsbs_pkg::MAX_ERRORS_DEFAULT;
      seq_phase              = fsbs_pkg::PH_RESET;
      seq_phase_start        = '0;
      seq_last_read          = '0;
      seq_failures           = '0;
      seq_scale              = '0;
      seq_offset             = '0;
      seq_unit               = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_bringup_sequence();
      test_zero_scale_and_limits();
      test_failure_saturation();
      test_random_at_defaults();
      test_random_fast_timing();
      test_random_long_waits();
      test_random_short_settings();
      test_random_wide_settings();
      drain_results();
      if (mismatches == 0) begin
         $display("flow_sensor_bringup_and_sample test passed");
      end else begin
         $display("flow_sensor_bringup_and_sample test failed");
      end
      $finish;
   end

endmodule
